@@ hw/rtl/bmf_pkg.sv @@
// Shared types, codes and constants of the backend message framer.
`default_nettype none

package bmf_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_LEN  = 2'd1,
    STATUS_BAD_BODY = 2'd2
  } status_t;

  // Decoded message kinds
  typedef enum logic [4:0] {
    MSG_UNKNOWN        = 5'd0,
    MSG_AUTH_OK        = 5'd1,
    MSG_AUTH_CLEARTEXT = 5'd2,
    MSG_AUTH_MD5       = 5'd3,
    MSG_AUTH_SASL      = 5'd4,
    MSG_ROW_DESC       = 5'd5,
    MSG_DATA_ROW       = 5'd6,
    MSG_CMD_COMPLETE   = 5'd7,
    MSG_READY          = 5'd8,
    MSG_ERROR          = 5'd9,
    MSG_NOTICE         = 5'd10,
    MSG_PARAM_STATUS   = 5'd11,
    MSG_KEY_DATA       = 5'd12,
    MSG_PARSE_COMPLETE = 5'd13,
    MSG_BIND_COMPLETE  = 5'd14,
    MSG_CLOSE_COMPLETE = 5'd15,
    MSG_NO_DATA        = 5'd16,
    MSG_PARAM_DESC     = 5'd17
  } msg_type_t;

  // Message tag bytes
  localparam logic [7:0] TAG_AUTH           = 8'h52;
  localparam logic [7:0] TAG_ROW_DESC       = 8'h54;
  localparam logic [7:0] TAG_DATA_ROW       = 8'h44;
  localparam logic [7:0] TAG_CMD_COMPLETE   = 8'h43;
  localparam logic [7:0] TAG_READY          = 8'h5A;
  localparam logic [7:0] TAG_ERROR          = 8'h45;
  localparam logic [7:0] TAG_NOTICE         = 8'h4E;
  localparam logic [7:0] TAG_PARAM_STATUS   = 8'h53;
  localparam logic [7:0] TAG_KEY_DATA       = 8'h4B;
  localparam logic [7:0] TAG_PARSE_COMPLETE = 8'h31;
  localparam logic [7:0] TAG_BIND_COMPLETE  = 8'h32;
  localparam logic [7:0] TAG_CLOSE_COMPLETE = 8'h33;
  localparam logic [7:0] TAG_NO_DATA        = 8'h6E;
  localparam logic [7:0] TAG_PARAM_DESC     = 8'h74;

  // Authentication subtypes
  localparam logic [31:0] AUTH_CODE_OK        = 32'd0;
  localparam logic [31:0] AUTH_CODE_CLEARTEXT = 32'd3;
  localparam logic [31:0] AUTH_CODE_MD5       = 32'd5;
  localparam logic [31:0] AUTH_CODE_SASL      = 32'd10;

  // Descriptor bytes after each column name
  localparam logic [4:0] SKIP_BYTES = 5'd18;

  // Configuration
  localparam int          CFG_ADDR_W      = 3;
  localparam logic        REG_COL_LIMIT   = 1'b0;
  localparam logic [14:0] COL_LIMIT_RESET = 15'd64;

  localparam int OUT_TDATA_W = 128;
  localparam int OUT_TUSER_W = 7;

  typedef struct packed {
    status_t          status;
    msg_type_t        msg_type;
    logic [7:0]       tag_byte;
    logic [15:0]      count_value;
    logic [31:0]      salt_word;
    logic [31:0]      backend_pid;
    logic [31:0]      cancel_key;
    logic             key_present;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/bmf_step.sv @@
// Framing state and per-byte decode of the backend message stream.
`default_nettype none

module bmf_step (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            advance,
  input  wire logic [7:0]      rx_byte,
  input  wire logic [14:0]     col_limit,
  output logic                 res_valid,
  output bmf_pkg::result_t     res
);

  logic [31:0] byte_position, byte_position_next;
  logic [7:0]  tag_reg, tag_reg_next;
  logic [31:0] length_reg, length_reg_next;
  logic [31:0] word_one, word_one_next;
  logic [31:0] word_two, word_two_next;
  logic [15:0] columns_left, columns_left_next;
  logic        column_phase, column_phase_next;
  logic [4:0]  skip_count, skip_count_next;

  logic [31:0]      len_shift;
  logic [31:0]      body_idx;
  logic [31:0]      fin_len;
  logic             bad_len;
  logic [15:0]      col_seed;
  logic [4:0]       skip_dec;
  bmf_pkg::result_t fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      tag_reg       <= '0;
      length_reg    <= '0;
      word_one      <= '0;
      word_two      <= '0;
      columns_left  <= '0;
      column_phase  <= 1'b0;
      skip_count    <= '0;
    end else if (advance) begin
      byte_position <= byte_position_next;
      tag_reg       <= tag_reg_next;
      length_reg    <= length_reg_next;
      word_one      <= word_one_next;
      word_two      <= word_two_next;
      columns_left  <= columns_left_next;
      column_phase  <= column_phase_next;
      skip_count    <= skip_count_next;
    end
  end

  always_comb begin
    byte_position_next = byte_position;
    tag_reg_next       = tag_reg;
    length_reg_next    = length_reg;
    word_one_next      = word_one;
    word_two_next      = word_two;
    columns_left_next  = columns_left;
    column_phase_next  = column_phase;
    skip_count_next    = skip_count;
    len_shift          = {length_reg[23:0], rx_byte};
    body_idx           = byte_position - 32'd5;
    fin_len            = length_reg;
    res_valid          = 1'b0;
    bad_len            = 1'b0;
    col_seed           = {word_one_next[31:16]};
    skip_dec           = skip_count - 5'd1;

    priority if (byte_position == 32'd0) begin
      tag_reg_next       = rx_byte;
      length_reg_next    = '0;
      word_one_next      = '0;
      word_two_next      = '0;
      columns_left_next  = '0;
      column_phase_next  = 1'b0;
      skip_count_next    = '0;
      byte_position_next = 32'd1;
    end else if (byte_position <= 32'd4) begin
      length_reg_next = len_shift;
      fin_len         = len_shift;
      priority if (byte_position < 32'd4) begin
        byte_position_next = byte_position + 32'd1;
      end else if (len_shift[31] || len_shift < 32'd4) begin
        byte_position_next = '0;
        res_valid          = 1'b1;
        bad_len            = 1'b1;
      end else if (len_shift == 32'd4) begin
        byte_position_next = '0;
        res_valid          = 1'b1;
      end else begin
        byte_position_next = 32'd5;
      end
    end else begin
      // place body bytes 0..7 into the two big-endian words
      if (body_idx < 32'd4) begin
        unique case (body_idx[1:0])
          2'd0: word_one_next[31:24] = rx_byte;
          2'd1: word_one_next[23:16] = rx_byte;
          2'd2: word_one_next[15:8]  = rx_byte;
          2'd3: word_one_next[7:0]   = rx_byte;
          default: word_one_next = word_one;
        endcase
      end else if (body_idx < 32'd8) begin
        unique case (body_idx[1:0])
          2'd0: word_two_next[31:24] = rx_byte;
          2'd1: word_two_next[23:16] = rx_byte;
          2'd2: word_two_next[15:8]  = rx_byte;
          2'd3: word_two_next[7:0]   = rx_byte;
          default: word_two_next = word_two;
        endcase
      end
      col_seed = word_one_next[31:16];

      // walk column descriptors of a row description
      if (tag_reg == bmf_pkg::TAG_ROW_DESC) begin
        if (body_idx == 32'd1) begin
          columns_left_next = col_seed[15] ? 16'd0 : col_seed;
          column_phase_next = 1'b0;
          skip_count_next   = '0;
        end else if (body_idx >= 32'd2 && columns_left != 16'd0) begin
          if (!column_phase) begin
            if (rx_byte == 8'd0) begin
              column_phase_next = 1'b1;
              skip_count_next   = bmf_pkg::SKIP_BYTES;
            end
          end else begin
            skip_count_next = skip_dec;
            if (skip_dec == 5'd0) begin
              columns_left_next = columns_left - 16'd1;
              column_phase_next = 1'b0;
            end
          end
        end
      end

      if (byte_position >= length_reg) begin
        byte_position_next = '0;
        res_valid          = 1'b1;
      end else begin
        byte_position_next = byte_position + 32'd1;
      end
    end
  end

  // Decode a finished message from its tag, length and collected words
  always_comb begin
    logic        bad;
    logic [15:0] n;
    bad             = 1'b0;
    n               = word_one_next[31:16];
    fin             = '0;
    fin.status      = bmf_pkg::STATUS_OK;
    fin.msg_type    = bmf_pkg::MSG_UNKNOWN;
    fin.tag_byte    = tag_reg;

    unique case (tag_reg)
      bmf_pkg::TAG_AUTH: begin
        if (fin_len < 32'd8) begin
          bad = 1'b1;
        end else if (word_one_next == bmf_pkg::AUTH_CODE_OK) begin
          fin.msg_type = bmf_pkg::MSG_AUTH_OK;
        end else if (word_one_next == bmf_pkg::AUTH_CODE_CLEARTEXT) begin
          fin.msg_type = bmf_pkg::MSG_AUTH_CLEARTEXT;
        end else if (word_one_next == bmf_pkg::AUTH_CODE_MD5) begin
          if (fin_len < 32'd12) begin
            bad = 1'b1;
          end else begin
            fin.msg_type  = bmf_pkg::MSG_AUTH_MD5;
            fin.salt_word = word_two_next;
          end
        end else if (word_one_next == bmf_pkg::AUTH_CODE_SASL) begin
          fin.msg_type = bmf_pkg::MSG_AUTH_SASL;
        end
      end
      bmf_pkg::TAG_ROW_DESC: begin
        if (fin_len < 32'd6 || columns_left_next != 16'd0) begin
          bad = 1'b1;
        end else begin
          fin.msg_type    = bmf_pkg::MSG_ROW_DESC;
          fin.count_value = ($signed(n) < $signed({1'b0, col_limit})) ? n
                                                                      : {1'b0, col_limit};
        end
      end
      bmf_pkg::TAG_DATA_ROW: begin
        if (fin_len < 32'd6) begin
          bad = 1'b1;
        end else begin
          fin.msg_type    = bmf_pkg::MSG_DATA_ROW;
          fin.count_value = n;
        end
      end
      bmf_pkg::TAG_CMD_COMPLETE:   fin.msg_type = bmf_pkg::MSG_CMD_COMPLETE;
      bmf_pkg::TAG_READY:          fin.msg_type = bmf_pkg::MSG_READY;
      bmf_pkg::TAG_ERROR:          fin.msg_type = bmf_pkg::MSG_ERROR;
      bmf_pkg::TAG_NOTICE:         fin.msg_type = bmf_pkg::MSG_NOTICE;
      bmf_pkg::TAG_PARAM_STATUS:   fin.msg_type = bmf_pkg::MSG_PARAM_STATUS;
      bmf_pkg::TAG_KEY_DATA: begin
        fin.msg_type = bmf_pkg::MSG_KEY_DATA;
        if (fin_len >= 32'd12) begin
          fin.backend_pid = word_one_next;
          fin.cancel_key  = word_two_next;
          fin.key_present = 1'b1;
        end
      end
      bmf_pkg::TAG_PARSE_COMPLETE: fin.msg_type = bmf_pkg::MSG_PARSE_COMPLETE;
      bmf_pkg::TAG_BIND_COMPLETE:  fin.msg_type = bmf_pkg::MSG_BIND_COMPLETE;
      bmf_pkg::TAG_CLOSE_COMPLETE: fin.msg_type = bmf_pkg::MSG_CLOSE_COMPLETE;
      bmf_pkg::TAG_NO_DATA:        fin.msg_type = bmf_pkg::MSG_NO_DATA;
      bmf_pkg::TAG_PARAM_DESC: begin
        fin.msg_type = bmf_pkg::MSG_PARAM_DESC;
        if (fin_len >= 32'd6) begin
          fin.count_value = n;
        end
      end
      default: fin.msg_type = bmf_pkg::MSG_UNKNOWN;
    endcase

    if (bad) begin
      fin          = '0;
      fin.status   = bmf_pkg::STATUS_BAD_BODY;
      fin.msg_type = bmf_pkg::MSG_UNKNOWN;
      fin.tag_byte = tag_reg;
    end
  end

  always_comb begin
    res = fin;
    if (bad_len) begin
      res          = '0;
      res.status   = bmf_pkg::STATUS_BAD_LEN;
      res.msg_type = bmf_pkg::MSG_UNKNOWN;
      res.tag_byte = tag_reg;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/backend_message_framer_core.sv @@
// Top level of the backend message framer: stream ports, register port, item stages.
`default_nettype none

// Byte-serial framer for a database backend message stream. Each message is a
// tag byte, a 4-byte big-endian length that counts itself, then the body; one
// result item leaves on the last byte of each message (on the last length byte
// when the length is bad or exactly 4). The block takes one byte per cycle
// sustained: a byte is captured in an input register, decoded by the framing
// counters and compares combinationally, and the result lands in an output
// register, so a new byte is accepted every cycle unless a result is waiting
// and the sink holds off. A last byte passes the input register and then the
// output register before its result is valid. col_limit (address 0) clamps
// the column count of row descriptions; write it only while the stream is idle.
module backend_message_framer_core (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // input stream
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [7:0]                         s_tdata,  // [7:0] rx_byte
  // result stream
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // [7:0] tag_byte, [23:8] count_value, [55:24] salt_word, [87:56] backend_pid,
  // [119:88] cancel_key, [120] key_present, [127:121] zero
  output logic [bmf_pkg::OUT_TDATA_W-1:0]         m_tdata,
  // [1:0] status, [6:2] msg_type
  output logic [bmf_pkg::OUT_TUSER_W-1:0]         m_tuser,
  // register port
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [bmf_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [31:0]                        pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready
);

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             advance;
  logic             res_valid;
  bmf_pkg::result_t res;
  bmf_pkg::result_t out_res;
  logic             out_valid;
  logic [14:0]      col_limit;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_limit <= bmf_pkg::COL_LIMIT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == bmf_pkg::REG_COL_LIMIT) begin
      col_limit <= pwdata[14:0];
    end
  end

  assign prdata = (paddr[2] == bmf_pkg::REG_COL_LIMIT) ? {17'd0, col_limit} : 32'd0;

  // process the held byte when the result slot is free or draining
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  bmf_step u_step (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .rx_byte   (in_byte),
    .col_limit (col_limit),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_res.key_present, out_res.cancel_key, out_res.backend_pid,
                     out_res.salt_word, out_res.count_value, out_res.tag_byte};
  assign m_tuser  = {out_res.msg_type, out_res.status};

`ifndef SYNTH
  // error results carry only the tag
  a_err_fields: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1:0] != bmf_pkg::STATUS_OK) |->
      (m_tuser[6:2] == bmf_pkg::MSG_UNKNOWN && m_tdata[127:8] == 120'd0))
    else $error("error result carries payload");

  a_key_kind: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[120]) |-> (m_tuser[6:2] == bmf_pkg::MSG_KEY_DATA))
    else $error("key_present outside key data");

  a_salt_kind: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[55:24] != 32'd0) |-> (m_tuser[6:2] == bmf_pkg::MSG_AUTH_MD5))
    else $error("salt outside md5 request");
`endif

endmodule

`default_nettype wire
